// ===== rtl/core/gsc_pkg.sv =====
// Package for the gas sensor concentration curve block.
// Register codes, reset values, fixed field widths, shared types.
// No dependencies.
package gsc_pkg;

   // default build parameters
   localparam int DEF_SAMPLE_BITS = 12;
   localparam int DEF_FRAC_BITS   = 16;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_SUPPLY_MV   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LOAD_OHMS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CLEAN_AIR   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DETECT_THR  = 2'd3;

   localparam int SUPPLY_W = 13;
   localparam int LOAD_W   = 20;
   localparam int RO_W     = 24;
   localparam int THR_W    = 12;

   localparam logic [SUPPLY_W-1:0] SUPPLY_RST = 13'd3300;
   localparam logic [LOAD_W-1:0]   LOAD_RST   = 20'd200000;
   localparam logic [RO_W-1:0]     RO_RST     = 24'd60000;
   localparam logic [THR_W-1:0]    THR_RST    = 12'd2048;

   // result fields
   localparam int MV_W   = 13;
   localparam int OHMS_W = 32;
   localparam int CONC_W = 24;
   localparam int RSP_DATA_W = 128;   // 125 bits of fields, padded to bytes
   localparam int RSP_USER_W = 3;

   // ratio x = 5*Ro/Rs is carried in 31 bits
   localparam int X_W     = 31;
   localparam int RO5_W   = 27;       // 5 * clean-air ohms
   localparam int RO_DIV  = 60;

   // serial divider control
   localparam int QB_W = 7;

   typedef struct packed {
      logic              start;
      logic [QB_W-1:0]   qbits;   // quotient bits to develop
   } div_ctl_type;

   // back-end sequencer
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_MV,
      ST_DIV_RS,
      ST_DIV_RO,
      ST_DIV_X,
      ST_SQRT,
      ST_MUL,
      ST_DIV_C,
      ST_DIV_P,
      ST_DONE
   } seq_state_type;

endpackage

// ===== rtl/core/gsc_front.sv =====
// Front end: configuration registers, input beat acceptance and the
// products that each sample needs. Depends on gsc_pkg.
module gsc_front #(
   parameter int SAMPLE_BITS = 12,
   parameter int ITEM_W      = 4 * 12 + 62
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [SAMPLE_BITS-1:0]             req_sample,
   input  logic                               csr_we,
   input  logic [gsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gsc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                               item_valid,
   input  logic                               item_ready,
   output logic [ITEM_W-1:0]                  item_data
);
   import gsc_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int MVP_W = SB + SUPPLY_W;
   localparam int NUM_W = SB + LOAD_W;
   localparam int N_W   = SB + RO5_W;
   localparam logic [SB-1:0] FS = {SB{1'b1}};

   logic [SUPPLY_W-1:0] supply_ff;
   logic [LOAD_W-1:0]   load_ff;
   logic [RO_W-1:0]     ro_ff;
   logic [THR_W-1:0]    thr_ff;

   logic               stg_valid_ff;
   logic [SB-1:0]      s_ff,   s_in;
   logic [MVP_W-1:0]   mvp_ff, mvp_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [N_W-1:0]     n_ff,   n_in;
   logic               det_ff, det_in;
   logic               zero_ff, zero_in;
   logic [RO5_W-1:0]   ro5;
   logic               advance;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= SUPPLY_RST;
         load_ff   <= LOAD_RST;
         ro_ff     <= RO_RST;
         thr_ff    <= THR_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_SUPPLY_MV:  supply_ff <= csr_wdata[SUPPLY_W-1:0];
            REG_LOAD_OHMS:  load_ff   <= csr_wdata[LOAD_W-1:0];
            REG_CLEAN_AIR:  ro_ff     <= csr_wdata[RO_W-1:0];
            REG_DETECT_THR: thr_ff    <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // per-sample products
   assign ro5     = (RO5_W'(ro_ff) << 2) + RO5_W'(ro_ff);
   assign s_in    = req_sample;
   assign mvp_in  = MVP_W'(req_sample) * MVP_W'(supply_ff);
   assign num_in  = NUM_W'(FS - req_sample) * NUM_W'(load_ff);
   assign n_in    = N_W'(req_sample) * N_W'(ro5);
   assign det_in  = (SB + THR_W)'(req_sample) > (SB + THR_W)'(thr_ff);
   assign zero_in = (req_sample == '0);

   assign advance    = !stg_valid_ff || item_ready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (advance) begin
         stg_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_tvalid) begin
         s_ff    <= s_in;
         mvp_ff  <= mvp_in;
         num_ff  <= num_in;
         n_ff    <= n_in;
         det_ff  <= det_in;
         zero_ff <= zero_in;
      end
   end

   assign item_valid = stg_valid_ff;
   assign item_data  = {zero_ff, det_ff, n_ff, num_ff, mvp_ff, s_ff};

endmodule

// ===== rtl/core/gsc_fifo.sv =====
// Two-entry queue between front and back end.
// Depends on nothing beyond its WIDTH parameter.
module gsc_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       cnt_ff;
   logic             push, pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== rtl/core/gsc_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// The caller gives the quotient length; the quotient must fit in it.
// Depends on gsc_pkg.
module gsc_div #(
   parameter int DW = 64,   // dividend and quotient width
   parameter int RW = 33    // remainder width, one above the divisor
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gsc_pkg::div_ctl_type  ctl,
   input  logic [DW-1:0]         dvd,
   input  logic [RW-2:0]         dvs,
   output logic                  done,
   output logic [DW-1:0]         quo
);
   import gsc_pkg::*;

   logic [RW-1:0]   rem_ff;
   logic [DW-1:0]   sh_ff;
   logic [DW-1:0]   quo_ff;
   logic [RW-2:0]   dvs_ff;
   logic [QB_W-1:0] cnt_ff;
   logic            done_ff;
   logic [RW-1:0]   trial;
   logic            ge;
   logic [QB_W-1:0] shamt;

   assign shamt = QB_W'(DW) - ctl.qbits;
   assign trial = {rem_ff[RW-2:0], sh_ff[DW-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   // step counter and completion pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (ctl.start) begin
         cnt_ff  <= ctl.qbits;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == QB_W'(1));
         if (cnt_ff != '0) cnt_ff <= cnt_ff - QB_W'(1);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff <= RW'(dvd >> ctl.qbits);
         sh_ff  <= dvd << shamt;
         quo_ff <= '0;
         dvs_ff <= dvs;
      end else if (cnt_ff != '0) begin
         rem_ff <= ge ? (trial - {1'b0, dvs_ff}) : trial;
         sh_ff  <= sh_ff << 1;
         quo_ff <= {quo_ff[DW-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/core/gsc_back.sv =====
// Back end: sequencer over the shared divider, square-root steps, the
// concentration product and result register. Depends on gsc_pkg, gsc_div.
module gsc_back #(
   parameter int SAMPLE_BITS = 12,
   parameter int FRAC_BITS   = 16,
   parameter int ITEM_W      = 4 * 12 + 62
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_valid,
   output logic                             item_ready,
   input  logic [ITEM_W-1:0]                item_data,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [gsc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [gsc_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import gsc_pkg::*;

   localparam int SB    = SAMPLE_BITS;
   localparam int F     = FRAC_BITS;
   localparam int MVP_W = SB + SUPPLY_W;
   localparam int NUM_W = SB + LOAD_W;
   localparam int N_W   = SB + RO5_W;
   localparam int SW    = (33 + F) / 2;     // root width
   localparam int VW    = 2 * SW;           // radicand width
   localparam int SRW   = SW + 2;
   localparam int PW    = X_W + SW;
   localparam int CW    = PW - F + 1;
   localparam int DW    = N_W + F;
   localparam int RW    = NUM_W + 1;
   localparam int CMW   = N_W + 32;
   localparam logic [SB-1:0] FS = {SB{1'b1}};

   // load voltage: reciprocal multiply for the division by full scale
   localparam int MV_S  = MVP_W + SB;
   localparam int MV_MW = MVP_W + 1;
   localparam int MV_PW = MVP_W + MV_MW;
   localparam logic [MV_MW-1:0] MV_M =
      MV_MW'(((64'd1 << MV_S) + 64'(FS) - 64'd1) / 64'(FS));

   // concentration: divide by 5 once the clip test has bounded the value
   localparam int PPW   = CONC_W + 3;
   localparam int C5_S  = PPW + 3;
   localparam int C5_MW = C5_S - 2;
   localparam int C5_PW = PPW + C5_MW;
   localparam logic [C5_MW-1:0] C5_M = C5_MW'(((64'd1 << C5_S) + 64'd4) / 64'd5);
   localparam logic [CW-1:0]    C_LIM = CW'(64'd5 << CONC_W);

   // promille: multiply by 21/10
   localparam int P_S  = CONC_W + 4;
   localparam int P_MW = P_S + 2;
   localparam int P_QW = CONC_W + 2;
   localparam int P_PW = CONC_W + P_MW;
   localparam logic [P_MW-1:0] P_M = P_MW'(((64'd21 << P_S) + 64'd9) / 64'd10);

   localparam int O_MVP  = SB;
   localparam int O_NUM  = O_MVP + MVP_W;
   localparam int O_N    = O_NUM + NUM_W;
   localparam int O_DET  = O_N + N_W;
   localparam int O_ZERO = O_DET + 1;

   seq_state_type state_ff, state_in;

   // fields of the head item
   logic [SB-1:0]    s_i;
   logic [MVP_W-1:0] mvp_i;

   // working registers
   logic [SB-1:0]    s_ff;
   logic [MVP_W-1:0] mvp_ff;
   logic [NUM_W-1:0] num_ff;
   logic [N_W-1:0]   n_ff;
   logic             det_ff, zero_ff, sat_ff;
   logic [MV_W-1:0]  mv_ff;
   logic [OHMS_W-1:0] rs_ff, ro_ff;
   logic [CONC_W-1:0] conc_ff, prom_ff;
   logic [X_W-1:0]   x_ff;
   logic [VW-1:0]    sq_v_ff;
   logic [SRW-1:0]   sq_rem_ff;
   logic [SW-1:0]    sq_root_ff;
   logic [QB_W-1:0]  sq_cnt_ff;
   logic [PW-1:0]    p_ff;
   logic [CONC_W-1:0] c_ff;
   logic             c_big_ff;

   logic             rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   div_ctl_type      div_ctl;
   logic [DW-1:0]    div_dvd, div_quo;
   logic [RW-2:0]    div_dvs;
   logic             div_done;

   logic             cap;
   logic             out_free;
   logic [SRW-1:0]   sq_trial, sq_cand;
   logic             sq_ge;
   logic [MV_PW-1:0] mv_prod;
   logic [CW-1:0]    pp;
   logic             pp_big;
   logic [C5_PW-1:0] c_prod;
   logic [P_PW-1:0]  p_prod;
   logic [P_QW-1:0]  prom_q;

   assign s_i   = item_data[SB-1:0];
   assign mvp_i = item_data[O_NUM-1:O_MVP];

   // ratio at or beyond the cap, or zero resistance
   assign cap = (num_ff == '0) ||
                (CMW'(n_ff) >= (CMW'(num_ff) << (X_W - F)));

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign item_ready = (state_ff == ST_IDLE);

   // constant divisions as reciprocal products
   assign mv_prod = MV_PW'(mvp_ff) * MV_PW'(MV_M);
   assign pp      = p_ff[PW-1:F-1];
   assign pp_big  = (pp >= C_LIM);
   assign c_prod  = C5_PW'(pp[PPW-1:0]) * C5_PW'(C5_M);
   assign p_prod  = P_PW'(c_ff) * P_PW'(P_M);
   assign prom_q  = p_prod[P_S +: P_QW];

   // square-root step
   assign sq_cand  = {sq_rem_ff[SRW-3:0], sq_v_ff[VW-1:VW-2]};
   assign sq_trial = {sq_root_ff, 2'b01};
   assign sq_ge    = sq_cand >= sq_trial;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (item_valid) state_in = ST_DIV_MV;
         ST_DIV_MV: state_in = zero_ff ? ST_DONE : ST_DIV_RS;
         ST_DIV_RS: if (div_done) state_in = ST_DIV_RO;
         ST_DIV_RO: if (div_done) state_in = cap ? ST_DONE : ST_DIV_X;
         ST_DIV_X:  if (div_done) state_in = ST_SQRT;
         ST_SQRT:   if (sq_cnt_ff == QB_W'(1)) state_in = ST_MUL;
         ST_MUL:    state_in = ST_DIV_C;
         ST_DIV_C:  state_in = ST_DIV_P;
         ST_DIV_P:  state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // divider commands, issued on the way into each division
   always_comb begin
      div_ctl = '0;
      div_dvd = '0;
      div_dvs = '0;
      case (state_ff)
         ST_DIV_MV: begin
            div_ctl.start = !zero_ff;
            div_ctl.qbits = QB_W'(NUM_W + 1);
            div_dvd = DW'(num_ff) + DW'(s_ff >> 1);
            div_dvs = (RW-1)'(s_ff);
         end
         ST_DIV_RS: begin
            div_ctl.start = div_done;
            div_ctl.qbits = QB_W'(NUM_W);
            div_dvd = DW'(num_ff) + DW'(s_ff) * DW'(RO_DIV / 2);
            div_dvs = (RW-1)'(s_ff) * (RW-1)'(RO_DIV);
         end
         ST_DIV_RO: begin
            div_ctl.start = div_done && !cap;
            div_ctl.qbits = QB_W'(X_W);
            div_dvd = DW'(n_ff) << F;
            div_dvs = num_ff;
         end
         default: ;
      endcase
   end

   gsc_div #(
      .DW (DW),
      .RW (RW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .dvd   (div_dvd),
      .dvs   (div_dvs),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_free) rsp_valid_ff <= (state_ff == ST_DONE);
      end
   end

   // working datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: if (item_valid) begin
            s_ff    <= s_i;
            mvp_ff  <= mvp_i + MVP_W'(FS >> 1);
            num_ff  <= item_data[O_N-1:O_NUM];
            n_ff    <= item_data[O_DET-1:O_N];
            det_ff  <= item_data[O_DET];
            zero_ff <= item_data[O_ZERO];
            sat_ff  <= 1'b0;
            rs_ff   <= '1;
            ro_ff   <= '1;
            conc_ff <= '0;
            prom_ff <= '0;
         end
         ST_DIV_MV: mv_ff <= mv_prod[MV_S +: MV_W];
         ST_DIV_RS: if (div_done) begin
            if (div_quo > DW'({OHMS_W{1'b1}})) begin
               rs_ff  <= '1;
               sat_ff <= 1'b1;
            end else begin
               rs_ff <= div_quo[OHMS_W-1:0];
            end
         end
         ST_DIV_RO: if (div_done) begin
            ro_ff <= div_quo[OHMS_W-1:0];
            if (cap) begin
               conc_ff <= '1;
               prom_ff <= '1;
               sat_ff  <= 1'b1;
            end
         end
         ST_DIV_X: if (div_done) begin
            x_ff       <= div_quo[X_W-1:0];
            sq_v_ff    <= VW'(div_quo[X_W-1:0]) << F;
            sq_rem_ff  <= '0;
            sq_root_ff <= '0;
            sq_cnt_ff  <= QB_W'(SW);
         end
         ST_SQRT: begin
            sq_rem_ff  <= sq_ge ? (sq_cand - sq_trial) : sq_cand;
            sq_root_ff <= {sq_root_ff[SW-2:0], sq_ge};
            sq_v_ff    <= sq_v_ff << 2;
            sq_cnt_ff  <= sq_cnt_ff - QB_W'(1);
         end
         ST_MUL: p_ff <= PW'(x_ff) * PW'(sq_root_ff);
         // c = p / (5 * 2^(F-1)); anything at 2^24 or above clips
         ST_DIV_C: begin
            c_ff     <= c_prod[C5_S +: CONC_W];
            c_big_ff <= pp_big;
         end
         ST_DIV_P: begin
            if (c_big_ff) begin
               conc_ff <= '1;
               prom_ff <= '1;
               sat_ff  <= 1'b1;
            end else begin
               conc_ff <= c_ff;
               if (prom_q > P_QW'({CONC_W{1'b1}})) begin
                  prom_ff <= '1;
                  sat_ff  <= 1'b1;
               end else begin
                  prom_ff <= prom_q[CONC_W-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (out_free && state_ff == ST_DONE) begin
         rsp_data_ff <= {3'b000, prom_ff, conc_ff, ro_ff, rs_ff, mv_ff};
         rsp_user_ff <= {zero_ff, sat_ff, det_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== rtl/core/gas_sensor_concentration_curve.sv =====
// Gas sensor concentration curve: load voltage, sensor resistance and
// power-law concentration for each converter beat. Top level; depends on
// gsc_pkg, gsc_front, gsc_fifo and gsc_back.
//
// Each request beat carries one converter sample. The response beat gives
// the load voltage in mV, the sensor resistance Rs and Rs/60 in ohms, the
// concentration 0.4*((Rs/Ro)/5)^-1.5 and 2.1 times it as unsigned fixed
// point with FRAC_BITS fraction bits, and flags for detection, clipping
// and a zero sample. The front stage takes a beat per cycle while the queue
// has room, and a two-entry queue holds samples for the back end. The back
// end works one sample at a time through a shared bit-serial divider and a
// bit-serial square root: a zero sample skips both, a sample whose ratio
// clips skips the ratio division, the square root and the product, and a
// full computation runs every step. The back end takes no new sample until
// the result of the last one is registered; a response held by rsp_tready
// keeps the back end waiting. Configuration registers take effect on the
// next sample.
module gas_sensor_concentration_curve #(
   parameter int SAMPLE_BITS = gsc_pkg::DEF_SAMPLE_BITS,
   parameter int FRAC_BITS   = gsc_pkg::DEF_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: sample in the low bits
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  req_tdata,
   // response tdata: load_mv, sensor_ohms, ro_estimate, concentration_q16,
   // promille_q16, zero padding
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gsc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // response tuser: detected, saturated, zero_sample
   output logic [gsc_pkg::RSP_USER_W-1:0]    rsp_tuser,
   // configuration writes
   input  logic                              csr_we,
   input  logic [gsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gsc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gsc_pkg::*;

   localparam int ITEM_W = 4 * SAMPLE_BITS + SUPPLY_W + LOAD_W + RO5_W + 2;

   logic              f_valid, f_ready;
   logic [ITEM_W-1:0] f_data;
   logic              q_valid, q_ready;
   logic [ITEM_W-1:0] q_data;

   gsc_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ITEM_W      (ITEM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_sample (req_tdata[SAMPLE_BITS-1:0]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (f_valid),
      .item_ready (f_ready),
      .item_data  (f_data)
   );

   gsc_fifo #(
      .WIDTH (ITEM_W)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   gsc_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .ITEM_W      (ITEM_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item_ready (q_ready),
      .item_data  (q_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
